FILE: rtl/core/gcbh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcbh_pkg
// Shared types and constants for the grid cell binning histogram: field
// widths, register indexes and reset values, controller states and the
// command and status groups passed between controller and datapath.
// ----------------------------------------------------------------------------
package gcbh_pkg;

    // Field widths fixed by the interface
    localparam int COORD_W   = 32;
    localparam int LABEL_W   = 7;
    localparam int COUNT_W   = 20;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_X_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_MIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_MAX = 2'd3;

    // Configuration reset values (signed Q16.16)
    localparam logic signed [COORD_W-1:0] X_MIN_RST = 32'sd0;
    localparam logic signed [COORD_W-1:0] X_MAX_RST = 32'sd655360;
    localparam logic signed [COORD_W-1:0] Z_MIN_RST = 32'sd0;
    localparam logic signed [COORD_W-1:0] Z_MAX_RST = 32'sd655360;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_LOAD,
        ST_DIV,
        ST_BIN,
        ST_READ,
        ST_UPDATE,
        ST_OUT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic cap_in;
        logic prep;
        logic div_load;
        logic div_step;
        logic bin;
        logic rd;
        logic upd;
        logic load_out;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic in_rect;
    } sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/gcbh_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcbh_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gcbh_ram #(
    parameter int WIDTH     = 20,
    parameter int DEPTH     = 100,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]     wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

FILE: rtl/core/gcbh_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcbh_div
// Restoring divider for the bin search: one quotient bit per step, with a
// flag for a non-zero remainder so the caller can round the quotient up.
// ----------------------------------------------------------------------------
module gcbh_div #(
    parameter int QBITS = 4
) (
    input  wire logic                                 clk,
    input  wire logic                                 load,
    input  wire logic                                 step,
    input  wire logic [gcbh_pkg::COORD_W+QBITS-1:0]   num,
    input  wire logic [gcbh_pkg::COORD_W-1:0]         span,
    output logic      [QBITS-1:0]                     quot,
    output logic                                      rem_nz
);

    localparam int NUM_W = gcbh_pkg::COORD_W + QBITS;

    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] dvs_reg;
    logic [QBITS-1:0] quot_reg;
    logic             ge;

    assign ge = (rem_reg >= dvs_reg);

    // Load the operands, then subtract the shifted divisor one bit a step
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg  <= num;
            dvs_reg  <= NUM_W'(span) << (QBITS - 1);
            quot_reg <= '0;
        end
        else if (step)
        begin
            rem_reg  <= ge ? (rem_reg - dvs_reg) : rem_reg;
            dvs_reg  <= dvs_reg >> 1;
            quot_reg <= (quot_reg << 1) | QBITS'(ge);
        end
    end

    assign quot   = quot_reg;
    assign rem_nz = |rem_reg;

endmodule
`default_nettype wire

FILE: rtl/core/gcbh_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcbh_ctrl
// Controller: sequences one point through offset, divide, bin, counter
// read-modify-write (inside points only) and output, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module gcbh_ctrl #(
    parameter int QBITS = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire gcbh_pkg::sts_t sts,
    output gcbh_pkg::cmd_t      cmd
);

    localparam int SB = (QBITS > 1) ? $clog2(QBITS) : 1;

    gcbh_pkg::state_t state_reg;
    gcbh_pkg::state_t state_next;
    logic [SB-1:0]    step_reg;
    logic [SB-1:0]    step_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    // State, step counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gcbh_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        case (state_reg)
            gcbh_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.cap_in = 1'b1;
                    state_next = gcbh_pkg::ST_PREP;
                end
            end
            gcbh_pkg::ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = gcbh_pkg::ST_LOAD;
            end
            gcbh_pkg::ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = gcbh_pkg::ST_DIV;
            end
            gcbh_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == SB'(QBITS - 1))
                begin
                    state_next = gcbh_pkg::ST_BIN;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            gcbh_pkg::ST_BIN:
            begin
                cmd.bin    = 1'b1;
                state_next = sts.in_rect ? gcbh_pkg::ST_READ : gcbh_pkg::ST_OUT;
            end
            gcbh_pkg::ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = gcbh_pkg::ST_UPDATE;
            end
            gcbh_pkg::ST_UPDATE:
            begin
                cmd.upd    = 1'b1;
                state_next = gcbh_pkg::ST_OUT;
            end
            gcbh_pkg::ST_OUT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = gcbh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gcbh_pkg::ST_IDLE;
            end
        endcase

        // Set on a new result, drop on a transfer
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

FILE: rtl/core/gcbh_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcbh_datapath
// Datapath: rectangle registers, point offsets, two bin dividers, cell label,
// counter RAM with per-cell valid bits, and the output register.
// ----------------------------------------------------------------------------
module gcbh_datapath #(
    parameter int GRID_COLS  = 10,
    parameter int GRID_ROWS  = 10,
    parameter int COUNT_BITS = 20
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [gcbh_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  wire logic [gcbh_pkg::COORD_W-1:0]          cfg_wr_data,
    input  wire logic signed [gcbh_pkg::COORD_W-1:0]   x_coord,
    input  wire logic signed [gcbh_pkg::COORD_W-1:0]   z_coord,
    input  wire logic                                  frame_start,
    input  wire gcbh_pkg::cmd_t                        cmd,
    output gcbh_pkg::sts_t                             sts,
    output logic [gcbh_pkg::LABEL_W-1:0]               cell_label,
    output logic [gcbh_pkg::COUNT_W-1:0]               cell_count,
    output logic                                       outside
);

    localparam int CW_IN     = gcbh_pkg::COORD_W;
    localparam int NUM_CELLS = GRID_COLS * GRID_ROWS;
    localparam int ADDR_BITS = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int GRID_MAX  = (GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS;
    localparam int QBITS     = $clog2(GRID_MAX + 1);
    localparam int NUM_W     = CW_IN + QBITS;
    localparam int BW        = QBITS + 1;
    localparam int LBL_RAW   = $clog2(NUM_CELLS + 1);
    localparam int LW        = (LBL_RAW > gcbh_pkg::LABEL_W) ? LBL_RAW : gcbh_pkg::LABEL_W;
    localparam int CNTW      = (COUNT_BITS > gcbh_pkg::COUNT_W) ? COUNT_BITS
                                                                 : gcbh_pkg::COUNT_W;

    // Rectangle registers
    logic signed [CW_IN-1:0] x_min_reg;
    logic signed [CW_IN-1:0] x_max_reg;
    logic signed [CW_IN-1:0] z_min_reg;
    logic signed [CW_IN-1:0] z_max_reg;

    // Point and per-axis working registers
    logic signed [CW_IN-1:0] x_reg;
    logic signed [CW_IN-1:0] z_reg;
    logic                    fs_reg;
    logic [CW_IN-1:0]        off_x_reg;
    logic [CW_IN-1:0]        span_x_reg;
    logic [CW_IN-1:0]        off_z_reg;
    logic [CW_IN-1:0]        span_z_reg;
    logic                    inside_reg;
    logic                    inside_next;

    // Divider interface
    logic [NUM_W-1:0]        num_x;
    logic [NUM_W-1:0]        num_z;
    logic [QBITS-1:0]        quot_x;
    logic [QBITS-1:0]        quot_z;
    logic                    rnz_x;
    logic                    rnz_z;

    // Bin and label
    logic [BW-1:0]           col_raw;
    logic [BW-1:0]           row_raw;
    logic [BW-1:0]           col;
    logic [BW-1:0]           row;
    logic [LW-1:0]           label_next;
    logic [LW-1:0]           idx_wide;
    logic [LW-1:0]           label_reg;
    logic [ADDR_BITS-1:0]    idx_reg;

    // Counter update
    logic [NUM_CELLS-1:0]    valid_reg;
    logic [NUM_CELLS-1:0]    valid_next;
    logic [COUNT_BITS-1:0]   rd_data;
    logic [COUNT_BITS-1:0]   cnt_cur;
    logic [COUNT_BITS-1:0]   cnt_inc;
    logic [COUNT_BITS-1:0]   cnt_res_reg;
    logic [CNTW-1:0]         cnt_wide;

    // Output register
    logic [gcbh_pkg::LABEL_W-1:0] cell_label_reg;
    logic [gcbh_pkg::COUNT_W-1:0] cell_count_reg;
    logic                         outside_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg <= gcbh_pkg::X_MIN_RST;
            x_max_reg <= gcbh_pkg::X_MAX_RST;
            z_min_reg <= gcbh_pkg::Z_MIN_RST;
            z_max_reg <= gcbh_pkg::Z_MAX_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                gcbh_pkg::CFG_X_MIN: x_min_reg <= cfg_wr_data;
                gcbh_pkg::CFG_X_MAX: x_max_reg <= cfg_wr_data;
                gcbh_pkg::CFG_Z_MIN: z_min_reg <= cfg_wr_data;
                gcbh_pkg::CFG_Z_MAX: z_max_reg <= cfg_wr_data;
                default:
                begin
                end
            endcase
        end
    end

    // Capture the point on transfer
    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            x_reg  <= x_coord;
            z_reg  <= z_coord;
            fs_reg <= frame_start;
        end
    end

    // Bounds check; offsets and spans wrap mod 2^32 but are exact when inside
    assign inside_next = (x_max_reg > x_min_reg) && (x_reg >= x_min_reg) &&
                         (x_reg <= x_max_reg) && (z_max_reg > z_min_reg) &&
                         (z_reg >= z_min_reg) && (z_reg <= z_max_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
        end
        else if (cmd.prep)
        begin
            inside_reg <= inside_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            off_x_reg  <= x_reg - x_min_reg;
            span_x_reg <= x_max_reg - x_min_reg;
            off_z_reg  <= z_reg - z_min_reg;
            span_z_reg <= z_max_reg - z_min_reg;
        end
    end

    assign sts.in_rect = inside_reg;

    // Scale offsets by the bin count and divide by the span
    assign num_x = NUM_W'(off_x_reg) * NUM_W'(GRID_COLS);
    assign num_z = NUM_W'(off_z_reg) * NUM_W'(GRID_ROWS);

    gcbh_div #(
        .QBITS (QBITS)
    ) u_div_x (
        .clk    (clk),
        .load   (cmd.div_load),
        .step   (cmd.div_step),
        .num    (num_x),
        .span   (span_x_reg),
        .quot   (quot_x),
        .rem_nz (rnz_x)
    );

    gcbh_div #(
        .QBITS (QBITS)
    ) u_div_z (
        .clk    (clk),
        .load   (cmd.div_load),
        .step   (cmd.div_step),
        .num    (num_z),
        .span   (span_z_reg),
        .quot   (quot_z),
        .rem_nz (rnz_z)
    );

    // Round up, clamp to the grid, form the row-major label
    always_comb
    begin
        col_raw = {1'b0, quot_x} + BW'(rnz_x);
        row_raw = {1'b0, quot_z} + BW'(rnz_z);

        if (col_raw == '0)
        begin
            col = BW'(1);
        end
        else if (col_raw > BW'(GRID_COLS))
        begin
            col = BW'(GRID_COLS);
        end
        else
        begin
            col = col_raw;
        end

        if (row_raw == '0)
        begin
            row = BW'(1);
        end
        else if (row_raw > BW'(GRID_ROWS))
        begin
            row = BW'(GRID_ROWS);
        end
        else
        begin
            row = row_raw;
        end

        label_next = LW'(row - 1'b1) * LW'(GRID_COLS) + LW'(col);
        idx_wide   = label_next - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.bin)
        begin
            label_reg <= inside_reg ? label_next : '0;
            idx_reg   <= idx_wide[ADDR_BITS-1:0];
        end
    end

    // Counter storage
    gcbh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_CELLS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.upd),
        .wr_addr (idx_reg),
        .wr_data (cnt_inc),
        .rd_en   (cmd.rd),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    // A cell not written since the last clear reads as zero; saturate
    assign cnt_cur = valid_reg[idx_reg] ? rd_data : '0;
    assign cnt_inc = (&cnt_cur) ? cnt_cur : (cnt_cur + 1'b1);

    // Per-cell valid bits: drop all on frame start, set on update
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.prep && fs_reg)
        begin
            valid_next = '0;
        end
        if (cmd.upd)
        begin
            valid_next[idx_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result count: zero unless the cell was updated
    always_ff @(posedge clk)
    begin
        if (cmd.bin)
        begin
            cnt_res_reg <= '0;
        end
        else if (cmd.upd)
        begin
            cnt_res_reg <= cnt_inc;
        end
    end

    assign cnt_wide = CNTW'(cnt_res_reg);

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            cell_label_reg <= label_reg[gcbh_pkg::LABEL_W-1:0];
            cell_count_reg <= cnt_wide[gcbh_pkg::COUNT_W-1:0];
            outside_reg    <= !inside_reg;
        end
    end

    assign cell_label = cell_label_reg;
    assign cell_count = cell_count_reg;
    assign outside    = outside_reg;

endmodule
`default_nettype wire

FILE: rtl/core/grid_cell_binning_histogram_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_cell_binning_histogram_top
// Bins points into a GRID_COLS by GRID_ROWS grid over a configured rectangle
// and keeps a saturating count per cell.
//
//   Channel  Handshake             Payload
//   -------  --------------------  -------------------------------------
//   in       in_valid / in_ready   x_coord, z_coord, frame_start
//   out      out_valid / out_ready cell_label, cell_count, outside
//   cfg      cfg_wr_en             cfg_addr, cfg_wr_data
//
// One point at a time: a counted point goes through offset, divide, bin,
// counter read and update and output; an outside point skips the counter.
// The restoring divider gives one quotient bit a cycle, for QBITS quotient
// bits per axis with QBITS = clog2(max(cols,rows)+1).
// Reset clears all counts at once through per-cell valid bits; no clearing
// pass. The output register holds a result while the next point is worked
// on; the block stalls only when a new result meets an untaken one.
// ----------------------------------------------------------------------------
module grid_cell_binning_histogram_top #(
    parameter int GRID_COLS  = 10,
    parameter int GRID_ROWS  = 10,
    parameter int COUNT_BITS = 20
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [gcbh_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  wire logic [gcbh_pkg::COORD_W-1:0]         cfg_wr_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [gcbh_pkg::COORD_W-1:0]  x_coord,
    input  wire logic signed [gcbh_pkg::COORD_W-1:0]  z_coord,
    input  wire logic                                 frame_start,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [gcbh_pkg::LABEL_W-1:0]              cell_label,
    output logic [gcbh_pkg::COUNT_W-1:0]              cell_count,
    output logic                                      outside
);

    localparam int GRID_MAX = (GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS;
    localparam int QBITS    = $clog2(GRID_MAX + 1);

    gcbh_pkg::cmd_t cmd;
    gcbh_pkg::sts_t sts;

    // Sequencer
    gcbh_ctrl #(
        .QBITS (QBITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Arithmetic and storage
    gcbh_datapath #(
        .GRID_COLS  (GRID_COLS),
        .GRID_ROWS  (GRID_ROWS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .x_coord     (x_coord),
        .z_coord     (z_coord),
        .frame_start (frame_start),
        .cmd         (cmd),
        .sts         (sts),
        .cell_label  (cell_label),
        .cell_count  (cell_count),
        .outside     (outside)
    );

`ifndef SYNTH
    // A transfer in starts work: no second point in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted twice in a row");

    // An outside point reports label and count zero
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && outside) |-> (cell_label == '0 && cell_count == '0))
        else $error("outside point with non-zero label or count");

    // Only points inside the rectangle touch the counters
    a_update_inside: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd |-> sts.in_rect)
        else $error("counter updated for an outside point");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/grid_cell_binning_histogram_top_test.sv
// ----------------------------------------------------------------------------
// grid_cell_binning_histogram_top_test
// Self-checking bench for the grid cell binning histogram. Points are sent
// over the input channel while a local bin predictor keeps its own copy of
// the rectangle and the per-cell tallies. Each transfer on the output
// channel is checked field by field against the oldest awaited cell result.
// Both channels idle at random, the receiver holds off for a long stretch
// once, and the rectangle is rewritten between phases while the block is
// idle: reset default, full 32-bit range, empty, narrow and random ones.
// ----------------------------------------------------------------------------
module grid_cell_binning_histogram_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LABEL_W   = gcbh_pkg::LABEL_W;
    localparam int COUNT_W   = gcbh_pkg::COUNT_W;
    localparam int COORD_W   = gcbh_pkg::COORD_W;
    localparam int CFG_IDX_W = gcbh_pkg::CFG_IDX_W;

    localparam logic [CFG_IDX_W-1:0] CFG_X_MIN = gcbh_pkg::CFG_X_MIN;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MAX = gcbh_pkg::CFG_X_MAX;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_MIN = gcbh_pkg::CFG_Z_MIN;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_MAX = gcbh_pkg::CFG_Z_MAX;

    localparam logic signed [COORD_W-1:0] X_MIN_RST = gcbh_pkg::X_MIN_RST;
    localparam logic signed [COORD_W-1:0] X_MAX_RST = gcbh_pkg::X_MAX_RST;
    localparam logic signed [COORD_W-1:0] Z_MIN_RST = gcbh_pkg::Z_MIN_RST;
    localparam logic signed [COORD_W-1:0] Z_MAX_RST = gcbh_pkg::Z_MAX_RST;

    localparam int GRID_COLS = 10;
    localparam int GRID_ROWS = 10;
    localparam int NUM_CELLS = GRID_COLS * GRID_ROWS;
    localparam int COUNT_BITS = 20;
    localparam int COUNT_MAX = (1 << COUNT_BITS) - 1;

    localparam int IDLE_PCT      = 20;
    localparam int STALL_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_MAX    = 10;
    localparam int REPEAT_POINTS = 120;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [COUNT_W-1:0] count;
        logic               outside;
    } cell_result_t;

    // Block ports
    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_addr = '0;
    logic [COORD_W-1:0]        cfg_wr_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [COORD_W-1:0] x_coord = '0;
    logic signed [COORD_W-1:0] z_coord = '0;
    logic                      frame_start = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [LABEL_W-1:0]        cell_label;
    logic [COUNT_W-1:0]        cell_count;
    logic                      outside;

    // Predictor copy of the rectangle and the cell tallies
    logic signed [COORD_W-1:0] x_lo = X_MIN_RST;
    logic signed [COORD_W-1:0] x_hi = X_MAX_RST;
    logic signed [COORD_W-1:0] z_lo = Z_MIN_RST;
    logic signed [COORD_W-1:0] z_hi = Z_MAX_RST;
    int                        cell_tally [NUM_CELLS];

    cell_result_t              awaited_cells [$];
    cell_result_t              head_cell;

    bit                        quiet = 1'b0;
    int                        stall_token = 0;
    int                        stall_seen = 0;
    int                        stall_left = 0;
    int                        cycles = 0;
    int                        mismatches = 0;
    int                        points_sent = 0;
    int                        results_seen = 0;
    int                        outside_seen = 0;
    int                        windows_set = 0;

    grid_cell_binning_histogram_top #(
        .GRID_COLS  (GRID_COLS),
        .GRID_ROWS  (GRID_ROWS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .x_coord     (x_coord),
        .z_coord     (z_coord),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cell_label  (cell_label),
        .cell_count  (cell_count),
        .outside     (outside)
    );

    // Clock
    always #1 clk = ~clk;

    // Guard against a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still awaited",
                     cycles, awaited_cells.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Exact 1-based bin along one axis, 0 when the value is not inside
    function automatic int axis_bin(input logic signed [COORD_W-1:0] v, lo, hi,
                                    input int nbins);
        longint span;
        longint off;
        longint b;
        if (hi <= lo || v < lo || v > hi)
            return 0;
        span = longint'(hi) - longint'(lo);
        off = longint'(v) - longint'(lo);
        if (off == 0)
            return 1;
        b = (longint'(nbins) * off + span - 1) / span;
        if (b < 1)
            b = 1;
        if (b > nbins)
            b = nbins;
        return int'(b);
    endfunction

    // Bin one point, update the tallies and return the cell result
    function automatic cell_result_t bin_point(input logic signed [COORD_W-1:0] x, z,
                                               input logic fs);
        cell_result_t r;
        int col;
        int row;
        int label;
        int idx;
        if (fs)
        begin
            foreach (cell_tally[i])
                cell_tally[i] = 0;
        end
        col = axis_bin(x, x_lo, x_hi, GRID_COLS);
        row = axis_bin(z, z_lo, z_hi, GRID_ROWS);
        r = '0;
        if (col == 0 || row == 0)
        begin
            r.outside = 1'b1;
            return r;
        end
        label = (row - 1) * GRID_COLS + col;
        idx = label - 1;
        if (idx >= NUM_CELLS)
            idx = NUM_CELLS - 1;
        if (cell_tally[idx] < COUNT_MAX)
            cell_tally[idx]++;
        r.label = LABEL_W'(label);
        r.count = COUNT_W'(cell_tally[idx]);
        return r;
    endfunction

    // Coordinate for one axis: mostly inside, often on a cell boundary,
    // sometimes just past an edge or anywhere at all
    function automatic logic signed [COORD_W-1:0] pick_coord(
        input logic signed [COORD_W-1:0] lo, hi);
        longint span;
        longint off;
        longint v;
        int     r;
        r = $urandom_range(0, 99);
        span = longint'(hi) - longint'(lo);
        if (span <= 0 || r < 10)
            return $urandom;
        if (r < 20)
        begin
            if (r < 15)
                v = longint'(lo) - 1 - longint'($urandom_range(0, 3));
            else
                v = longint'(hi) + 1 + longint'($urandom_range(0, 3));
            if (v < -64'sd2147483648 || v > 64'sd2147483647)
                return $urandom;
            return v[COORD_W-1:0];
        end
        if (r < 50)
        begin
            off = (longint'($urandom_range(0, 10)) * span) / 10;
            off = off + int'($urandom_range(0, 2)) - 1;
            if (off < 0)
                off = 0;
            if (off > span)
                off = span;
        end
        else
            off = longint'($urandom) % (span + 1);
        v = longint'(lo) + off;
        return v[COORD_W-1:0];
    endfunction

    // Pick one axis of a random rectangle: anything, narrow, empty or wide
    task automatic pick_axis(output logic signed [COORD_W-1:0] lo, hi);
        longint a;
        longint b;
        int     kind;
        kind = $urandom_range(0, 9);
        a = longint'($signed($urandom));
        if (kind < 2)
            b = longint'($signed($urandom));
        else if (kind < 5)
            b = a + longint'($urandom_range(1, 40));
        else if (kind == 5)
            b = a;
        else
            b = a + longint'($urandom_range(1, 32'h7FFFFFFF));
        if (b > 64'sd2147483647)
            b = 64'sd2147483647;
        lo = a[COORD_W-1:0];
        hi = b[COORD_W-1:0];
    endtask

    // Send one point; entered and left at a rising edge, valid held until transfer
    task automatic send_point(input logic signed [COORD_W-1:0] x, z, input logic fs);
        int gap;
        gap = 0;
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        x_coord     <= x;
        z_coord     <= z;
        frame_start <= fs;
        do
            @(posedge clk);
        while (!in_ready);
        awaited_cells.push_back(bin_point(x, z, fs));
        points_sent++;
    endtask

    // Drop valid and wait until every awaited result has arrived
    task automatic settle();
        in_valid <= 1'b0;
        while (awaited_cells.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register and update the predictor copy; write enable left high
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic signed [COORD_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(posedge clk);
        case (idx)
            CFG_X_MIN: x_lo = value;
            CFG_X_MAX: x_hi = value;
            CFG_Z_MIN: z_lo = value;
            CFG_Z_MAX: z_hi = value;
            default: ;
        endcase
    endtask

    // Rewrite the whole rectangle; only called while the block is idle
    task automatic set_window(input logic signed [COORD_W-1:0] xl, xh, zl, zh);
        write_reg(CFG_X_MIN, xl);
        write_reg(CFG_X_MAX, xh);
        write_reg(CFG_Z_MIN, zl);
        write_reg(CFG_Z_MAX, zh);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        windows_set++;
    endtask

    // Random points over the current rectangle with occasional frame starts
    task automatic send_random_points(input int n);
        for (int i = 0; i < n; i++)
            send_point(pick_coord(x_lo, x_hi), pick_coord(z_lo, z_hi),
                       $urandom_range(0, 99) < 5);
    endtask

    // Receiver: check each transfer, then choose the next ready
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (outside)
                outside_seen++;
            if (awaited_cells.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("Unexpected result: label %0d count %0d outside %0b",
                             cell_label, cell_count, outside);
            end
            else
            begin
                head_cell = awaited_cells.pop_front();
                if (head_cell.label !== cell_label || head_cell.count !== cell_count ||
                    head_cell.outside !== outside)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("Mismatch at result %0d: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                                 results_seen, head_cell.label, head_cell.count,
                                 head_cell.outside, cell_label, cell_count, outside);
                end
            end
        end
        if (stall_token != stall_seen)
        begin
            stall_seen = stall_token;
            stall_left = STALL_CYCLES;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (quiet)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Edges, cell boundaries, outside points and frame start on the reset rectangle
    task automatic test_directed_edges();
        send_point(0, 0, 1'b1);
        send_point(X_MAX_RST, Z_MAX_RST, 1'b0);
        send_point(X_MAX_RST, 0, 1'b0);
        send_point(0, Z_MAX_RST, 1'b0);
        send_point(1, 1, 1'b0);
        send_point(65536, 65536, 1'b0);
        send_point(65537, 65537, 1'b0);
        send_point(-1, 0, 1'b0);
        send_point(X_MAX_RST + 1, 0, 1'b0);
        send_point(0, -1, 1'b0);
        send_point(0, Z_MAX_RST + 1, 1'b0);
        send_point(32'sh80000000, 32'sh7FFFFFFF, 1'b0);
        send_point(32'sh7FFFFFFF, 32'sh80000000, 1'b0);
        // Frame start on an outside point still clears the tallies
        send_point(-1, -1, 1'b1);
        send_point(0, 0, 1'b0);
        send_point(327680, 327680, 1'b0);
        settle();
    endtask

    // Pile many points into one cell back to back, then clear it with a frame start
    task automatic test_repeat_cell();
        quiet = 1'b1;
        set_window(X_MIN_RST, X_MAX_RST, Z_MIN_RST, Z_MAX_RST);
        send_point(262145, 327681, 1'b1);
        for (int i = 0; i < REPEAT_POINTS; i++)
            send_point(262145 + $urandom_range(0, 65535), 327681 + $urandom_range(0, 65535),
                       1'b0);
        send_point(327680, 393216, 1'b1);
        settle();
        quiet = 1'b0;
    endtask

    // Rectangle over the whole signed 32-bit range on both axes
    task automatic test_full_range_window();
        set_window(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
        send_point(32'sh80000000, 32'sh80000000, 1'b1);
        send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
        send_point(32'sh80000000, 32'sh7FFFFFFF, 1'b0);
        send_point(32'sh7FFFFFFF, 32'sh80000000, 1'b0);
        send_point(0, -1, 1'b0);
        send_random_points(60);
        settle();
    endtask

    // Zero-width and reversed rectangles flag every point
    task automatic test_empty_window();
        set_window(5, 5, Z_MIN_RST, Z_MAX_RST);
        send_point(5, 0, 1'b0);
        send_random_points(15);
        settle();
        set_window(X_MIN_RST, X_MAX_RST, 100, -100);
        send_point(0, 0, 1'b1);
        send_random_points(15);
        settle();
        set_window(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
        send_random_points(10);
        settle();
    endtask

    // Hold the output off for a long stretch while points keep coming
    task automatic test_backpressure();
        set_window(-327680, 196608, -1310720, -65536);
        stall_token++;
        send_random_points(40);
        settle();
    endtask

    // Random rectangles, one phase with no idling on either side
    task automatic test_random_windows();
        logic signed [COORD_W-1:0] xl;
        logic signed [COORD_W-1:0] xh;
        logic signed [COORD_W-1:0] zl;
        logic signed [COORD_W-1:0] zh;
        for (int p = 0; p < 6; p++)
        begin
            pick_axis(xl, xh);
            pick_axis(zl, zh);
            set_window(xl, xh, zl, zh);
            quiet = (p == 2);
            send_random_points(50);
            settle();
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_edges();
        test_repeat_cell();
        test_full_range_window();
        test_empty_window();
        test_backpressure();
        test_random_windows();
        $display("Sent %0d points over %0d rectangles, checked %0d results (%0d outside)",
                 points_sent, windows_set, results_seen, outside_seen);
        $display("Covered edges, cell boundaries, empty and full-range rectangles, %s",
                 "repeated counts in one cell and output stalls");
        if (mismatches == 0 && awaited_cells.size() == 0)
            $display("Testbench completed without errors");
        else
        begin
            $display("%0d mismatches, %0d results never arrived", mismatches,
                     awaited_cells.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/gcbh_pkg.sv
rtl/core/gcbh_ram.sv
rtl/core/gcbh_div.sv
rtl/core/gcbh_ctrl.sv
rtl/core/gcbh_datapath.sv
rtl/core/grid_cell_binning_histogram_top.sv
tb/sv/grid_cell_binning_histogram_top_test.sv
